FILE: hdl/vat_pkg.sv
`timescale 1ns / 1ps
package vat_pkg;

    // transform kinds held in the mode register
    localparam logic [1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [1:0] MODE_ROTATE    = 2'd1;
    localparam logic [1:0] MODE_SCALE     = 2'd2;
    localparam logic [1:0] MODE_PASS      = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_VEC_X = 3'd1;
    localparam logic [2:0] REG_VEC_Y = 3'd2;
    localparam logic [2:0] REG_VEC_Z = 3'd3;
    localparam logic [2:0] REG_ANGLE = 3'd4;

    localparam int TABLE_LEN = 24;
    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] Q30_GAIN    = 34'sd652032875;

    // one vertex word as it moves through the queue
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } t_vertex;

    // rotation matrix rows 0..2, columns 0..2
    typedef logic signed [31:0] t_mat3 [3][3];

    function automatic logic signed [33:0] arctan_q30(input logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // saturate a 66-bit value to 32 bits signed
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage

FILE: hdl/vertex_affine_transform.sv
`timescale 1ns / 1ps
// Vertex transform: [x y z 1] times a 4x4 matrix chosen by the mode register.
// Input stream s_axis carries one vertex word per beat, x, y, z and tlast.
// Output stream m_axis returns the transformed, saturated vertex in order.
// Configuration writes (cfg_valid/cfg_ready, index, data) set mode, vector
// and angle; writes only while no vertex is in flight.
// A write of vec or angle starts the rotation matrix builder, or restarts
// it if it is running: it runs the CORDIC micro-rotations on one shared
// stage, a rounding step, then the 9 elements on one shared multiplier,
// each in two product steps and an element step; vertices wait for it,
// and config writes are always taken.
// Throughput is one vertex per cycle while the matrix builder is idle and
// the output is not stalled; an accepted word passes the queue, then the
// product, sum and round stages, before its result is presented.
// When m_axis_tready is low the output register holds, the pipeline and
// the four-entry queue fill, then s_axis_tready falls.
// Reset clears the configuration registers to zero (translate by zero),
// empties the pipeline and runs the matrix builder once.
module vertex_affine_transform
    import vat_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // x_in, y_in, z_in
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // x_out, y_out, z_out
    output logic        m_axis_tlast,   // last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [1:0]         r_mode;
    logic signed [31:0] r_vx, r_vy, r_vz;
    logic signed [18:0] r_angle;
    logic               r_start;
    logic               w_busy, w_full, w_empty, w_take;
    t_vertex            w_in, w_q;
    t_vertex            w_out;
    t_mat3              w_m;

    assign cfg_ready = 1'b1;

    // register writes; vector or angle write rebuilds the rotation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_TRANSLATE;
            r_vx <= '0; r_vy <= '0; r_vz <= '0; r_angle <= '0;
            r_start <= 1'b1;
        end else begin
            r_start <= 1'b0;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MODE:  r_mode <= cfg_data[1:0];
                    REG_VEC_X: begin r_vx <= cfg_data; r_start <= 1'b1; end
                    REG_VEC_Y: begin r_vy <= cfg_data; r_start <= 1'b1; end
                    REG_VEC_Z: begin r_vz <= cfg_data; r_start <= 1'b1; end
                    REG_ANGLE: begin r_angle <= cfg_data[18:0]; r_start <= 1'b1; end
                    default: ;
                endcase
            end
        end
    end

    vat_mat #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_mat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_vx(r_vx), .i_vy(r_vy), .i_vz(r_vz), .i_angle(r_angle),
        .o_busy(w_busy), .o_m(w_m)
    );

    assign w_in = '{x: s_axis_tdata[31:0], y: s_axis_tdata[63:32],
                    z: s_axis_tdata[95:64], last: s_axis_tlast};
    assign s_axis_tready = !w_full;

    vat_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(s_axis_tvalid && !w_full), .i_data(w_in), .o_full(w_full),
        .i_rd(w_take), .o_empty(w_empty), .o_data(w_q)
    );

    vat_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(!w_empty && !w_busy && !r_start), .i_v(w_q), .o_take(w_take),
        .i_mode(r_mode), .i_vx(r_vx), .i_vy(r_vy), .i_vz(r_vz), .i_m(w_m),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_v(w_out)
    );

    assign m_axis_tdata = {w_out.z, w_out.y, w_out.x};
    assign m_axis_tlast = w_out.last;
endmodule

FILE: hdl/vat_mat.sv
`timescale 1ns / 1ps
// Builds the rotation matrix from the registers with a sequencer that
// shares one CORDIC stage and one multiplier. Runs on i_start (a vector or
// angle write), and starts over if another start arrives while it is running.
module vat_mat
    import vat_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_vx,
    input  logic signed [31:0] i_vy,
    input  logic signed [31:0] i_vz,
    input  logic signed [18:0] i_angle,
    output logic               o_busy,
    output t_mat3              o_m
);
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int SH    = 30 - FRAC_BITS;
    localparam logic signed [65:0] HALF_F = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [33:0] HALF_S = 34'sd1 <<< (SH - 1);
    localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CORD = 5'b00010,
        S_FIN  = 5'b00100,
        S_PROD = 5'b01000,
        S_ELEM = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic signed [33:0] r_cx, r_cy, r_ca;
    logic               r_neg;
    logic [4:0]         r_step;
    logic signed [31:0] r_s, r_c, r_omc;
    logic [1:0]         r_row, r_col;
    logic               r_phase;
    logic signed [31:0] r_t;
    t_mat3              r_m;

    logic signed [33:0] w_a0;
    logic signed [33:0] w_xs, w_ys;
    logic signed [31:0] w_ra, w_rb, w_rs, w_rsgn;
    logic               w_diag, w_sub;
    logic signed [31:0] w_ma, w_mb;
    logic signed [31:0] w_prod;
    logic signed [33:0] w_cx_f, w_cy_f;
    logic [1:0]         w_row, w_col;

    assign w_a0 = 34'(i_angle) <<< SH;
    assign w_xs = r_cx >>> r_step;
    assign w_ys = r_cy >>> r_step;
    assign w_cx_f = r_neg ? -r_cx : r_cx;
    assign w_cy_f = r_neg ? -r_cy : r_cy;
    assign w_row = r_row;
    assign w_col = r_col;

    // pick operands of the element under work
    always_comb begin
        logic signed [31:0] ax [3];
        ax[0] = i_vx; ax[1] = i_vy; ax[2] = i_vz;
        w_ra = ax[w_row];
        w_rb = ax[w_col];
        w_diag = (w_row == w_col);
        w_sub = 1'b0;
        w_rs = ax[0];
        unique case ({w_row, w_col})
            4'b0001: begin w_rs = ax[2]; w_sub = 1'b1; end
            4'b0010: begin w_rs = ax[1]; w_sub = 1'b0; end
            4'b0100: begin w_rs = ax[2]; w_sub = 1'b0; end
            4'b0110: begin w_rs = ax[0]; w_sub = 1'b1; end
            4'b1000: begin w_rs = ax[1]; w_sub = 1'b1; end
            4'b1001: begin w_rs = ax[0]; w_sub = 1'b0; end
            default: begin w_rs = ax[0]; w_sub = 1'b0; end
        endcase
        w_rsgn = w_rs;
        // shared multiplier operands
        priority if (r_state == S_PROD && !r_phase) begin
            w_ma = w_ra; w_mb = w_rb;
        end else if (r_state == S_PROD) begin
            w_ma = r_t; w_mb = r_omc;
        end else begin
            w_ma = w_rsgn; w_mb = r_s;
        end
    end

    // one rounded Q product
    always_comb begin
        logic signed [65:0] p;
        p = (66'(w_ma) * 66'(w_mb) + HALF_F) >>> FRAC_BITS;
        w_prod = sat32(p);
    end

    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = S_CORD;
        end else begin
            unique case (r_state)
                S_IDLE: ;
                S_CORD: if (32'(r_step) == STEPS - 1) n_state = S_FIN;
                S_FIN:  n_state = S_PROD;
                S_PROD: if (r_phase) n_state = S_ELEM;
                S_ELEM: n_state = (r_row == 2'd2 && r_col == 2'd2) ? S_IDLE : S_PROD;
                default: n_state = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (i_start) begin
            // load the CORDIC from the current angle, reduced once by pi
            r_step <= '0;
            r_row <= '0;
            r_col <= '0;
            r_phase <= 1'b0;
            r_cx <= Q30_GAIN;
            r_cy <= '0;
            if (w_a0 > Q30_HALF_PI) begin
                r_ca <= w_a0 - Q30_PI; r_neg <= 1'b1;
            end else if (w_a0 < -Q30_HALF_PI) begin
                r_ca <= w_a0 + Q30_PI; r_neg <= 1'b1;
            end else begin
                r_ca <= w_a0; r_neg <= 1'b0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: ;
                S_CORD: begin
                    // one micro-rotation per cycle
                    if (r_ca >= 0) begin
                        r_cx <= r_cx - w_ys; r_cy <= r_cy + w_xs;
                        r_ca <= r_ca - arctan_q30(r_step);
                    end else begin
                        r_cx <= r_cx + w_ys; r_cy <= r_cy - w_xs;
                        r_ca <= r_ca + arctan_q30(r_step);
                    end
                    r_step <= r_step + 5'd1;
                end
                S_FIN: begin
                    r_c <= 32'((w_cx_f + HALF_S) >>> SH);
                    r_s <= 32'((w_cy_f + HALF_S) >>> SH);
                    r_omc <= sat32(ONE - 66'(32'((w_cx_f + HALF_S) >>> SH)));
                end
                S_PROD: begin
                    r_phase <= ~r_phase;
                    r_t <= w_prod;
                end
                S_ELEM: begin
                    // diagonal adds cos, others add or subtract the sine term
                    if (w_diag) r_m[w_row][w_col] <= sat32(66'(r_c) + 66'(r_t));
                    else if (w_sub) r_m[w_row][w_col] <= sat32(66'(r_t) - 66'(w_prod));
                    else r_m[w_row][w_col] <= sat32(66'(r_t) + 66'(w_prod));
                    // advance column, then row
                    if (r_col == 2'd2) begin
                        r_col <= 2'd0;
                        r_row <= r_row + 2'd1;
                    end else begin
                        r_col <= r_col + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_m = r_m;
endmodule

FILE: hdl/vat_fifo.sv
`timescale 1ns / 1ps
// Short queue between the front and the back.
module vat_fifo
    import vat_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_vertex i_data,
    output logic    o_full,
    input  logic    i_rd,
    output logic    o_empty,
    output t_vertex o_data
);
    t_vertex    r_mem [4];
    logic [2:0] r_wp, r_rp;

    assign o_full  = (r_wp[1:0] == r_rp[1:0]) && (r_wp[2] != r_rp[2]);
    assign o_empty = (r_wp == r_rp);
    assign o_data  = r_mem[r_rp[1:0]];

    // advance pointers on each word moved
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 3'd1;
            if (i_rd) r_rp <= r_rp + 3'd1;
        end
        if (i_wr) r_mem[r_wp[1:0]] <= i_data;
    end
endmodule

FILE: hdl/vat_back.sv
`timescale 1ns / 1ps
// Matrix product pipeline: multiply, sum, round and saturate, output register.
module vat_back
    import vat_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_vertex            i_v,
    output logic               o_take,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_vx,
    input  logic signed [31:0] i_vy,
    input  logic signed [31:0] i_vz,
    input  t_mat3              i_m,
    output logic               o_valid,
    input  logic               i_ready,
    output t_vertex            o_v
);
    localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);

    logic               r_p1v, r_p2v, r_ov;
    logic signed [63:0] r_p [3][3];
    logic signed [31:0] r_t [3];
    logic               r_l1, r_l2;
    logic signed [65:0] r_sum [3];
    t_vertex            r_o;
    logic               w_adv2, w_adv1;
    logic signed [31:0] w_m [3][3];
    logic signed [31:0] w_tr [3];

    // effective matrix for the mode
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) w_m[i][j] = (i == j) ? ONE32 : 32'sd0;
            w_tr[i] = 32'sd0;
        end
        unique case (i_mode)
            MODE_TRANSLATE: begin w_tr[0] = i_vx; w_tr[1] = i_vy; w_tr[2] = i_vz; end
            MODE_SCALE: begin w_m[0][0] = i_vx; w_m[1][1] = i_vy; w_m[2][2] = i_vz; end
            MODE_ROTATE: w_m = i_m;
            MODE_PASS: ;
            default: ;
        endcase
    end

    assign w_adv2 = !r_ov || i_ready;
    assign w_adv1 = !r_p2v || w_adv2;
    assign o_take = i_valid && (!r_p1v || w_adv1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0; r_p2v <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (!r_p1v || w_adv1) r_p1v <= i_valid;
            if (w_adv1) r_p2v <= r_p1v;
            if (w_adv2) r_ov <= r_p2v;
        end
        // stage 1: products
        if (o_take) begin
            for (int j = 0; j < 3; j++) begin
                r_p[0][j] <= 64'(i_v.x) * 64'(w_m[0][j]);
                r_p[1][j] <= 64'(i_v.y) * 64'(w_m[1][j]);
                r_p[2][j] <= 64'(i_v.z) * 64'(w_m[2][j]);
                r_t[j] <= w_tr[j];
            end
            r_l1 <= i_v.last;
        end
        // stage 2: exact sums
        if (r_p1v && w_adv1) begin
            for (int j = 0; j < 3; j++)
                r_sum[j] <= 66'(r_p[0][j]) + 66'(r_p[1][j]) + 66'(r_p[2][j])
                          + (66'(r_t[j]) <<< FRAC_BITS);
            r_l2 <= r_l1;
        end
        // stage 3: round and saturate into the output register
        if (r_p2v && w_adv2) begin
            r_o.x <= sat32((r_sum[0] + HALF) >>> FRAC_BITS);
            r_o.y <= sat32((r_sum[1] + HALF) >>> FRAC_BITS);
            r_o.z <= sat32((r_sum[2] + HALF) >>> FRAC_BITS);
            r_o.last <= r_l2;
        end
    end

    assign o_valid = r_ov;
    assign o_v = r_o;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |=> r_ov && $stable(r_o)) else $error("output dropped");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> i_valid) else $error("take without word");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2v && w_adv2 |=> r_ov) else $error("pipeline lost word");
endmodule

FILE: tb/vertex_affine_transform_tb.sv
`timescale 1ns / 1ps
module vertex_affine_transform_tb;
    import vat_pkg::*;

    localparam int FRAC = 16;
    localparam int STEPS = 16;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint ATAN_Q30 [16] = '{
        843314857, 497837829, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;   // x_in, y_in, z_in
    logic        s_axis_tlast = 1'b0; // last_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // x_out, y_out, z_out
    logic        m_axis_tlast;        // last_out
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // shadow copy of the transform registers
    logic [1:0]         sh_mode = MODE_TRANSLATE;
    logic signed [31:0] sh_vx = '0, sh_vy = '0, sh_vz = '0;
    logic signed [18:0] sh_angle = '0;

    t_vertex expected_vertices [$];
    int  n_fail = 0;
    bit  idle_on = 1'b1;
    int  stall_req = 0;
    int  stall_seen = 0;
    int  stall_left = 0;
    int  rx_gap = 0;

    vertex_affine_transform u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint clamp32(input longint v);
        if (v > I32_MAX) return I32_MAX;
        if (v < I32_MIN) return I32_MIN;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return clamp32((a * b + (64'sd1 << (FRAC - 1))) >>> FRAC);
    endfunction

    // CORDIC rotation for sine and cosine, with one reduction by pi
    function automatic void fx_sincos(input longint ang, output longint s,
                                      output longint c);
        longint a, x, y, nx;
        bit     flip;
        a = ang * (64'sd1 << (30 - FRAC));
        x = Q30_GAIN;
        y = 0;
        flip = 1'b0;
        if (a > Q30_HALF_PI) begin
            a = a - Q30_PI;
            flip = 1'b1;
        end else if (a < -Q30_HALF_PI) begin
            a = a + Q30_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                a = a - ATAN_Q30[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                a = a + ATAN_Q30[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        s = (y + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
    endfunction

    // transform one vertex by the matrix the shadow registers select
    function automatic t_vertex transform_vertex(input t_vertex v);
        longint  vin [4];
        longint  m [4][4];
        longint  s, c, omc, rx, ry, rz, p, h, hi, lo;
        t_vertex r;
        vin[0] = v.x;
        vin[1] = v.y;
        vin[2] = v.z;
        vin[3] = ONE;
        rx = sh_vx;
        ry = sh_vy;
        rz = sh_vz;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                m[i][j] = (i == j) ? ONE : 0;
        case (sh_mode)
            MODE_TRANSLATE: begin
                m[3][0] = rx; m[3][1] = ry; m[3][2] = rz;
            end
            MODE_SCALE: begin
                m[0][0] = rx; m[1][1] = ry; m[2][2] = rz;
            end
            MODE_ROTATE: begin
                fx_sincos(longint'(sh_angle), s, c);
                omc = clamp32(ONE - c);
                m[0][0] = clamp32(c + fx_mul(fx_mul(rx, rx), omc));
                m[0][1] = clamp32(fx_mul(fx_mul(rx, ry), omc) - fx_mul(rz, s));
                m[0][2] = clamp32(fx_mul(fx_mul(rx, rz), omc) + fx_mul(ry, s));
                m[1][0] = clamp32(fx_mul(fx_mul(ry, rx), omc) + fx_mul(rz, s));
                m[1][1] = clamp32(c + fx_mul(fx_mul(ry, ry), omc));
                m[1][2] = clamp32(fx_mul(fx_mul(ry, rz), omc) - fx_mul(rx, s));
                m[2][0] = clamp32(fx_mul(fx_mul(rz, rx), omc) - fx_mul(ry, s));
                m[2][1] = clamp32(fx_mul(fx_mul(rz, ry), omc) + fx_mul(rx, s));
                m[2][2] = clamp32(c + fx_mul(fx_mul(rz, rz), omc));
            end
            default: ;
        endcase
        for (int j = 0; j < 3; j++) begin
            hi = 0;
            lo = 0;
            for (int i = 0; i < 4; i++) begin
                p = vin[i] * m[i][j];
                h = p >>> FRAC;
                hi = hi + h;
                lo = lo + (p - h * ONE);
            end
            p = clamp32(hi + ((lo + (64'sd1 << (FRAC - 1))) >>> FRAC));
            if (j == 0) r.x = p[31:0];
            else if (j == 1) r.y = p[31:0];
            else r.z = p[31:0];
        end
        r.last = v.last;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom;
        if (r < 8) return 32'($urandom_range(0, 32'h7ffff)) - 32'h40000;
        if (r == 8) return 32'h7fffffff;
        return 32'h80000000;
    endfunction

    // receiver: random holds, plus one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_seen != stall_req) begin
            stall_seen <= stall_req;
            stall_left <= 300;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_gap <= pick_gap();
        end
    end

    // compare each output word with the oldest expected vertex
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_vertices.size() == 0) begin
                $error("unexpected output word %h", m_axis_tdata);
                n_fail++;
            end else begin
                e = expected_vertices.pop_front();
                if (m_axis_tdata[31:0] !== e.x) begin
                    $error("x_out expected %h got %h", e.x, m_axis_tdata[31:0]);
                    n_fail++;
                end
                if (m_axis_tdata[63:32] !== e.y) begin
                    $error("y_out expected %h got %h", e.y, m_axis_tdata[63:32]);
                    n_fail++;
                end
                if (m_axis_tdata[95:64] !== e.z) begin
                    $error("z_out expected %h got %h", e.z, m_axis_tdata[95:64]);
                    n_fail++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_out expected %b got %b", e.last, m_axis_tlast);
                    n_fail++;
                end
            end
        end
    end

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic last);
        t_vertex v;
        int      gap;
        v.x = x;
        v.y = y;
        v.z = z;
        v.last = last;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_vertices.push_back(transform_vertex(v));
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_vertex();
        send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
    endtask

    // hold the sender until every expected word is back, then settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            REG_MODE:  sh_mode = val[1:0];
            REG_VEC_X: sh_vx = val;
            REG_VEC_Y: sh_vy = val;
            REG_VEC_Z: sh_vz = val;
            REG_ANGLE: sh_angle = val[18:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_transform(input logic [1:0] md, input logic [31:0] vx,
                                 input logic [31:0] vy, input logic [31:0] vz,
                                 input logic [31:0] ang);
        drain();
        write_reg(REG_MODE, {30'd0, md});
        write_reg(REG_VEC_X, vx);
        write_reg(REG_VEC_Y, vy);
        write_reg(REG_VEC_Z, vz);
        write_reg(REG_ANGLE, ang);
    endtask

    task automatic send_extremes();
        send_vertex(32'h7fffffff, 32'h80000000, 32'h0, 1'b0);
        send_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1);
        send_vertex(32'h00010000, 32'hffff0000, 32'h00008000, 1'b0);
    endtask

    task automatic test_reset_state();
        send_extremes();
    endtask

    task automatic test_translate();
        set_transform(MODE_TRANSLATE, 32'h7fffffff, 32'h80000000, 32'h00012345, 0);
        send_extremes();
        set_transform(MODE_TRANSLATE, 32'h80000000, 32'h7fffffff, 32'hfffe0000, 0);
        send_extremes();
    endtask

    task automatic test_scale();
        set_transform(MODE_SCALE, 32'h7fffffff, 32'h80000000, 32'h00020000, 0);
        send_extremes();
        set_transform(MODE_SCALE, 32'h00008000, 32'hffff0000, 32'h0, 0);
        send_extremes();
    endtask

    task automatic test_rotate();
        // unit axes at angles of plus and minus pi
        set_transform(MODE_ROTATE, 32'h0, 32'h0, 32'h00010000, 32'd205887);
        send_extremes();
        set_transform(MODE_ROTATE, 32'd37837, 32'd37837, 32'd37837, -32'sd205887);
        send_extremes();
        // angle beyond pi and an axis far from unit length
        set_transform(MODE_ROTATE, 32'h7fffffff, 32'h80000000, 32'h00030000,
                      32'h0003ffff);
        send_extremes();
        set_transform(MODE_ROTATE, 32'h00010000, 32'h0, 32'h0, 32'hfffc0000);
        send_extremes();
    endtask

    task automatic test_pass_mode();
        set_transform(MODE_PASS, 32'h12345678, 32'h87654321, 32'h7fffffff, 32'd1000);
        send_extremes();
    endtask

    task automatic test_backpressure();
        set_transform(MODE_TRANSLATE, 32'h00010000, 32'h0, 32'hffff0000, 0);
        idle_on = 1'b0;
        stall_req++;
        repeat (40) send_random_vertex();
        drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        logic [1:0]  md;
        logic [31:0] vx, vy, vz;
        for (int ph = 0; ph < 10; ph++) begin
            md = ($urandom_range(0, 9) == 0) ? MODE_PASS : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 1)) begin
                vx = rand_coord(); vy = rand_coord(); vz = rand_coord();
            end else begin
                case ($urandom_range(0, 3))
                    0: begin vx = 32'h10000; vy = 0; vz = 0; end
                    1: begin vx = 0; vy = 32'h10000; vz = 0; end
                    2: begin vx = 0; vy = 0; vz = 32'hffff0000; end
                    default: begin vx = 32'd37837; vy = -32'sd37837; vz = 32'd37837; end
                endcase
            end
            set_transform(md, vx, vy, vz, $urandom);
            idle_on = (ph % 3) != 1;
            repeat (48) send_random_vertex();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_translate();
        test_scale();
        test_rotate();
        test_pass_mode();
        test_backpressure();
        test_random();
        drain();
        repeat (20) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
